[sv/tfd_pkg.sv]
// ----------------------------------------------------------------------------
// tfd_pkg
// Shared widths, register codes and types of the time/frequency decimator.
// ----------------------------------------------------------------------------
package tfd_pkg;

    // Default storage limits, handed to the top level as parameter defaults
    localparam int MAX_CHANS_DEF = 4096;
    localparam int MAX_IFS_DEF   = 4;

    // Fixed limits of the datapath
    localparam int MAX_FACTOR  = 256;
    localparam int SAMPLE_BITS = 16;

    // Result field widths
    localparam int VALUE_W    = 24;
    localparam int OUT_CHAN_W = 12;
    localparam int IF_IDX_W   = 2;

    // Configuration port and register widths
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 13;
    localparam int CHAN_COUNT_W = 13;
    localparam int IF_COUNT_W   = 3;
    localparam int FACTOR_W     = 9;

    // Internal arithmetic widths
    localparam int SUM_W  = 32;
    localparam int FPOS_W = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;
    localparam int FVAL_W = $clog2(MAX_FACTOR + 1);
    localparam int TSUM_W = SAMPLE_BITS + FPOS_W;

    // Register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHAN_COUNT  = 2'd0,
        REG_IF_COUNT    = 2'd1,
        REG_TIME_FACTOR = 2'd2,
        REG_CHAN_FACTOR = 2'd3
    } cfg_reg_t;

    // Divider status toward its user
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

[sv/tfd_if.sv]
// ----------------------------------------------------------------------------
// tfd_if
// Valid/ready channels of the decimator: sample items in, result items out.
// ----------------------------------------------------------------------------
interface tfd_in_if
    import tfd_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface tfd_out_if
    import tfd_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [VALUE_W-1:0]    value;
    logic [OUT_CHAN_W-1:0] out_channel;
    logic [IF_IDX_W-1:0]   if_index;
    logic                  config_error;

    modport source (output valid, output value, output out_channel,
                    output if_index, output config_error, input ready);
    modport sink   (input valid, input value, input out_channel,
                    input if_index, input config_error, output ready);
endinterface

[sv/time_frequency_decimator.sv]
// ----------------------------------------------------------------------------
// time_frequency_decimator
// Sums time_factor samples per IF and channel, then averages chan_factor
// adjacent channels into one 24-bit result per channel group.
// ----------------------------------------------------------------------------
// Samples are taken at one item per cycle unless a group-completing item is
// held off. The running time sums live in a MAX_IFS*MAX_CHANS entry RAM that
// is read when an item is accepted and written back in the following cycle,
// with a bypass when neighboring items hit the same entry. The RAM needs no
// clearing pass: on the first sample of a time group the old contents of the
// entry are ignored. The channel-group average runs on a shared serial
// divider; an item that completes a channel group is held off while the
// previous division is still running or its result has not been moved to
// the output register. With chan_factor of 1 and time_factor of 1 every item
// makes a result, so each item waits for the division of the one before it.
// After each configuration write the same divider checks that chan_factor
// divides chan_count, which holds off result-making items until it is done.
// ----------------------------------------------------------------------------
module time_frequency_decimator
    import tfd_pkg::*;
#(
    parameter int MAX_CHANS = MAX_CHANS_DEF,
    parameter int MAX_IFS   = MAX_IFS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    tfd_in_if.sink                samples,
    tfd_out_if.source             results,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data
);

    localparam int CPOS_W = (MAX_CHANS > 1) ? $clog2(MAX_CHANS) : 1;
    localparam int IPOS_W = (MAX_IFS > 1) ? $clog2(MAX_IFS) : 1;
    localparam int DEPTH  = MAX_CHANS * MAX_IFS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Configuration registers
    logic [CHAN_COUNT_W-1:0] chan_count_reg;
    logic [IF_COUNT_W-1:0]   if_count_reg;
    logic [FACTOR_W-1:0]     time_factor_reg;
    logic [FACTOR_W-1:0]     chan_factor_reg;
    logic                    check_pend_reg;
    logic                    divisible_reg, divisible_next;

    // Stream position counters
    logic [CPOS_W-1:0] chan_pos_reg, chan_pos_next;
    logic [IPOS_W-1:0] if_pos_reg, if_pos_next;
    logic [FPOS_W-1:0] time_pos_reg, time_pos_next;
    logic [FPOS_W-1:0] grp_pos_reg, grp_pos_next;
    logic [CPOS_W-1:0] grp_cnt_reg, grp_cnt_next;

    // Write-back stage
    logic                   b_valid_reg;
    logic [SAMPLE_BITS-1:0] b_sample_reg;
    logic [ADDR_W-1:0]      b_addr_reg;
    logic                   b_first_reg;
    logic                   b_last_reg;
    logic                   b_emit_reg;
    logic                   b_wrap_reg;
    logic [CPOS_W-1:0]      b_chan_reg;
    logic [IPOS_W-1:0]      b_if_reg;
    logic                   fwd_hit_reg;
    logic [TSUM_W-1:0]      fwd_data_reg;
    logic [SUM_W-1:0]       partial_reg, partial_next;

    // Divider job and output register
    logic                  job_check_reg;
    logic [CPOS_W-1:0]     job_chan_reg;
    logic [IPOS_W-1:0]     job_if_reg;
    logic                  out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]    out_value_reg;
    logic [OUT_CHAN_W-1:0] out_chan_reg;
    logic [IF_IDX_W-1:0]   out_if_reg;
    logic                  out_err_reg;

    // Clamped configuration
    logic [CPOS_W-1:0] cc_m1;
    logic [IPOS_W-1:0] ic_m1;
    logic [FPOS_W-1:0] tf_m1;
    logic [FVAL_W-1:0] cf_val;
    logic [FPOS_W-1:0] cf_m1;
    logic [SUM_W-1:0]  cc_val;
    logic              cfg_bad;

    logic              chan_last, if_last, time_last, grp_last, emit_a;
    logic              in_acc;
    logic [ADDR_W-1:0] a_addr;
    logic [TSUM_W-1:0] ram_rdata, old_sum, tsum;
    logic [SUM_W-1:0]  group_sum;

    logic              div_start, div_ack, out_free, out_load;
    logic [SUM_W-1:0]  div_dividend;
    div_status_t       div_stat;
    logic [SUM_W-1:0]  div_quo;
    logic [FVAL_W-1:0] div_rem;

    // Range clamps of the configuration registers
    always_comb
    begin
        if (chan_count_reg == '0)
            cc_m1 = '0;
        else if (int'(chan_count_reg) > MAX_CHANS)
            cc_m1 = CPOS_W'(MAX_CHANS - 1);
        else
            cc_m1 = CPOS_W'(chan_count_reg - 1'b1);

        if (if_count_reg == '0)
            ic_m1 = '0;
        else if (int'(if_count_reg) > MAX_IFS)
            ic_m1 = IPOS_W'(MAX_IFS - 1);
        else
            ic_m1 = IPOS_W'(if_count_reg - 1'b1);

        if (time_factor_reg == '0)
            tf_m1 = '0;
        else if (int'(time_factor_reg) > MAX_FACTOR)
            tf_m1 = FPOS_W'(MAX_FACTOR - 1);
        else
            tf_m1 = FPOS_W'(time_factor_reg - 1'b1);

        if (chan_factor_reg == '0)
            cf_val = FVAL_W'(1);
        else if (int'(chan_factor_reg) > MAX_FACTOR)
            cf_val = FVAL_W'(MAX_FACTOR);
        else
            cf_val = FVAL_W'(chan_factor_reg);
    end

    assign cf_m1  = FPOS_W'(cf_val - 1'b1);
    assign cc_val = SUM_W'(cc_m1) + SUM_W'(1);

    assign cfg_bad = (time_factor_reg == '0) || (int'(time_factor_reg) > MAX_FACTOR)
                  || (chan_factor_reg == '0) || (int'(chan_factor_reg) > MAX_FACTOR)
                  || !divisible_reg;

    // Position of the item at the input
    assign chan_last = (chan_pos_reg == cc_m1);
    assign if_last   = (if_pos_reg == ic_m1);
    assign time_last = (time_pos_reg == tf_m1);
    assign grp_last  = (grp_pos_reg == cf_m1);
    assign emit_a    = time_last && grp_last;

    // A group-completing item waits for a free divider
    assign samples.ready = !(emit_a && (div_stat.busy || div_stat.done || check_pend_reg
                                        || (b_valid_reg && b_emit_reg)));
    assign in_acc = samples.valid && samples.ready;

    assign a_addr = ADDR_W'(SUM_W'(if_pos_reg) * SUM_W'(MAX_CHANS) + SUM_W'(chan_pos_reg));

    // Counter update per accepted item; a config write restarts the stream
    always_comb
    begin
        chan_pos_next = chan_pos_reg;
        if_pos_next   = if_pos_reg;
        time_pos_next = time_pos_reg;
        grp_pos_next  = grp_pos_reg;
        grp_cnt_next  = grp_cnt_reg;
        if (wr_en)
        begin
            chan_pos_next = '0;
            if_pos_next   = '0;
            time_pos_next = '0;
            grp_pos_next  = '0;
            grp_cnt_next  = '0;
        end
        else if (in_acc)
        begin
            if (time_last)
                grp_pos_next = grp_last ? '0 : grp_pos_reg + 1'b1;
            if (emit_a)
                grp_cnt_next = grp_cnt_reg + 1'b1;
            if (chan_last)
            begin
                chan_pos_next = '0;
                grp_pos_next  = '0;
                grp_cnt_next  = '0;
                if (if_last)
                begin
                    if_pos_next   = '0;
                    time_pos_next = time_last ? '0 : time_pos_reg + 1'b1;
                end
                else
                begin
                    if_pos_next = if_pos_reg + 1'b1;
                end
            end
            else
            begin
                chan_pos_next = chan_pos_reg + 1'b1;
            end
        end
    end

    // Time-sum store
    tfd_ram #(
        .WIDTH (TSUM_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (b_valid_reg),
        .waddr (b_addr_reg),
        .wdata (tsum),
        .re    (in_acc),
        .raddr (a_addr),
        .rdata (ram_rdata)
    );

    // Read-modify-write with bypass of the entry written last cycle
    assign old_sum   = fwd_hit_reg ? fwd_data_reg : ram_rdata;
    assign tsum      = b_first_reg ? TSUM_W'(b_sample_reg)
                                   : old_sum + TSUM_W'(b_sample_reg);
    assign group_sum = partial_reg + SUM_W'(tsum);

    // Channel-group running sum
    always_comb
    begin
        partial_next = partial_reg;
        if (wr_en)
        begin
            partial_next = '0;
        end
        else if (b_valid_reg)
        begin
            if (b_last_reg)
                partial_next = b_emit_reg ? '0 : group_sum;
            if (b_wrap_reg)
                partial_next = '0;
        end
    end

    // Divider jobs: divisibility check after a write, else a group average
    assign div_start    = check_pend_reg || (b_valid_reg && b_emit_reg);
    assign div_dividend = check_pend_reg ? cc_val : group_sum;

    tfd_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (FVAL_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .ack       (div_ack),
        .dividend  (div_dividend),
        .divisor   (cf_val),
        .status    (div_stat),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign out_free = !out_valid_reg || results.ready;
    assign div_ack  = div_stat.done && (job_check_reg || out_free);
    assign out_load = div_stat.done && !job_check_reg && out_free;

    always_comb
    begin
        divisible_next = divisible_reg;
        if (div_stat.done && job_check_reg)
            divisible_next = (div_rem == '0);
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (results.ready)
            out_valid_next = 1'b0;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_count_reg  <= CHAN_COUNT_W'(1);
            if_count_reg    <= IF_COUNT_W'(1);
            time_factor_reg <= FACTOR_W'(1);
            chan_factor_reg <= FACTOR_W'(1);
            check_pend_reg  <= 1'b0;
            divisible_reg   <= 1'b1;
            chan_pos_reg    <= '0;
            if_pos_reg      <= '0;
            time_pos_reg    <= '0;
            grp_pos_reg     <= '0;
            grp_cnt_reg     <= '0;
            b_valid_reg     <= 1'b0;
            fwd_hit_reg     <= 1'b0;
            partial_reg     <= '0;
            job_check_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                unique case (cfg_reg_t'(wr_index))
                    REG_CHAN_COUNT:  chan_count_reg  <= wr_data[CHAN_COUNT_W-1:0];
                    REG_IF_COUNT:    if_count_reg    <= wr_data[IF_COUNT_W-1:0];
                    REG_TIME_FACTOR: time_factor_reg <= wr_data[FACTOR_W-1:0];
                    REG_CHAN_FACTOR: chan_factor_reg <= wr_data[FACTOR_W-1:0];
                endcase
            end
            check_pend_reg <= wr_en;
            divisible_reg  <= divisible_next;
            chan_pos_reg   <= chan_pos_next;
            if_pos_reg     <= if_pos_next;
            time_pos_reg   <= time_pos_next;
            grp_pos_reg    <= grp_pos_next;
            grp_cnt_reg    <= grp_cnt_next;
            b_valid_reg    <= in_acc;
            fwd_hit_reg    <= in_acc && b_valid_reg && (a_addr == b_addr_reg);
            partial_reg    <= partial_next;
            if (div_start)
                job_check_reg <= check_pend_reg;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            b_sample_reg <= samples.sample;
            b_addr_reg   <= a_addr;
            b_first_reg  <= (time_pos_reg == '0);
            b_last_reg   <= time_last;
            b_emit_reg   <= emit_a;
            b_wrap_reg   <= chan_last;
            b_chan_reg   <= grp_cnt_reg;
            b_if_reg     <= if_pos_reg;
        end
        fwd_data_reg <= tsum;
        if (div_start)
        begin
            job_chan_reg <= b_chan_reg;
            job_if_reg   <= b_if_reg;
        end
        if (out_load)
        begin
            out_value_reg <= VALUE_W'(div_quo);
            out_chan_reg  <= OUT_CHAN_W'(job_chan_reg);
            out_if_reg    <= IF_IDX_W'(job_if_reg);
            out_err_reg   <= cfg_bad;
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.value        = out_value_reg;
    assign results.out_channel  = out_chan_reg;
    assign results.if_index     = out_if_reg;
    assign results.config_error = out_err_reg;

endmodule

[sv/tfd_ram.sv]
// ----------------------------------------------------------------------------
// tfd_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// A read at the address being written returns the old contents.
// ----------------------------------------------------------------------------
module tfd_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
)
(
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[sv/tfd_div.sv]
// ----------------------------------------------------------------------------
// tfd_div
// Radix-2 restoring divider, one quotient bit per cycle. The result holds
// until acknowledged; a start restarts the unit at any time.
// ----------------------------------------------------------------------------
module tfd_div
    import tfd_pkg::*;
#(
    parameter int DIVIDEND_W = SUM_W,
    parameter int DIVISOR_W  = FVAL_W
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  ack,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output div_status_t           status,
    output logic [DIVIDEND_W-1:0] quotient,
    output logic [DIVISOR_W-1:0]  remainder
);

    localparam int CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dsr_reg, dsr_next;
    logic [DIVISOR_W+1:0]  trial;

    // One shift-subtract step
    assign trial = {1'b0, rem_reg, quo_reg[DIVIDEND_W-1]} - {2'b00, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            cnt_next  = CNT_W'(DIVIDEND_W - 1);
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial[DIVISOR_W+1])
            begin
                rem_next = trial[DIVISOR_W-1:0] + dsr_reg;
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b0};
            end
            else
            begin
                rem_next = trial[DIVISOR_W-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b1};
            end
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
        else if (ack)
        begin
            done_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;
    assign remainder   = rem_reg;

endmodule

[sv/tfd_checker.sv]
// ----------------------------------------------------------------------------
// tfd_checker
// Port-level assertions of the decimator, bound to the top level.
// ----------------------------------------------------------------------------
module tfd_checker
    import tfd_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [VALUE_W-1:0]    value,
    input logic [OUT_CHAN_W-1:0] out_channel,
    input logic [IF_IDX_W-1:0]   if_index,
    input logic                  config_error,
    input logic                  wr_en,
    input logic [CFG_IDX_W-1:0]  wr_index,
    input logic [CFG_DATA_W-1:0] wr_data
);

    logic [31:0] in_cnt_reg;
    logic [31:0] out_cnt_reg;
    logic        tf_zero_reg;
    logic        cf_zero_reg;
    logic        out_valid_q;
    logic        out_ready_q;
    logic        new_item;

    // Shadow of the factors, item counts and last handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_cnt_reg  <= '0;
            out_cnt_reg <= '0;
            tf_zero_reg <= 1'b0;
            cf_zero_reg <= 1'b0;
            out_valid_q <= 1'b0;
            out_ready_q <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                in_cnt_reg <= in_cnt_reg + 32'd1;
            if (out_valid && out_ready)
                out_cnt_reg <= out_cnt_reg + 32'd1;
            if (wr_en && (wr_index == REG_TIME_FACTOR))
                tf_zero_reg <= (wr_data[FACTOR_W-1:0] == '0);
            if (wr_en && (wr_index == REG_CHAN_FACTOR))
                cf_zero_reg <= (wr_data[FACTOR_W-1:0] == '0);
            out_valid_q <= out_valid;
            out_ready_q <= out_ready;
        end
    end

    assign new_item = out_valid && (!out_valid_q || out_ready_q);

    // A waiting result item stays offered
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result item withdrawn while stalled");

    // A waiting result item keeps its payload
    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(value) && $stable(out_channel)
                                    && $stable(if_index) && $stable(config_error))
        else $error("result payload changed while stalled");

    // Every result item comes from an earlier accepted sample item
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |-> out_cnt_reg < in_cnt_reg)
        else $error("more result items than sample items");

    // A zero factor flags every new result
    a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
        new_item && ($past(tf_zero_reg) || $past(cf_zero_reg)) |-> config_error)
        else $error("zero factor without config_error");

endmodule

bind time_frequency_decimator tfd_checker u_tfd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (samples.valid),
    .in_ready     (samples.ready),
    .out_valid    (results.valid),
    .out_ready    (results.ready),
    .value        (results.value),
    .out_channel  (results.out_channel),
    .if_index     (results.if_index),
    .config_error (results.config_error),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data)
);

[dv/time_frequency_decimator_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// time_frequency_decimator_test
// Self-checking bench for the filterbank time/frequency decimator. A short
// table of directed items and register writes is walked first, then three
// directed phases and random register settings with random sample streams follow.
// An item-level model of the decimation predicts the result items that the table
// does not give; both channel sides idle at random and the result side holds off
// once for a long stretch so that the block backs up into its sample input.
// ----------------------------------------------------------------------------
module time_frequency_decimator_test;
    import tfd_pkg::*;

    localparam int STORE_DEPTH  = MAX_CHANS_DEF * MAX_IFS_DEF;
    localparam int DRAIN_CYCLES = 64;
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_ITEMS = 1550;

    typedef struct packed {
        logic [VALUE_W-1:0]    value;
        logic [OUT_CHAN_W-1:0] out_channel;
        logic [IF_IDX_W-1:0]   if_index;
        logic                  config_error;
    } tfd_result_t;

    // One row of the directed table: a register write or a sample item
    typedef struct {
        bit                     is_write;
        cfg_reg_t               reg_idx;
        logic [CFG_DATA_W-1:0]  data;
        logic [SAMPLE_BITS-1:0] sample;
        bit                     typed;
        tfd_result_t            want;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  wr_en;
    logic [CFG_IDX_W-1:0]  wr_index;
    logic [CFG_DATA_W-1:0] wr_data;

    tfd_in_if  in_ch ();
    tfd_out_if out_ch ();

    time_frequency_decimator DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .samples  (in_ch),
        .results  (out_ch),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Predictor state: register copies, running time sums, stream position
    logic [CHAN_COUNT_W-1:0] cfg_chan_count;
    logic [IF_COUNT_W-1:0]   cfg_if_count;
    logic [FACTOR_W-1:0]     cfg_time_factor;
    logic [FACTOR_W-1:0]     cfg_chan_factor;

    logic [SUM_W-1:0] time_sums [STORE_DEPTH];
    logic [12:0]      pos_chan;
    logic [2:0]       pos_if;
    logic [8:0]       pos_group;
    logic [8:0]       pos_time;
    logic [SUM_W-1:0] group_acc;

    tfd_result_t pending_results [$];
    int          err_count;
    bit          steady;
    bit          long_hold;

    function automatic int unsigned clamp_to(input int unsigned v, input int unsigned hi);
        if (v == 0)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Advance the decimation model by one sample; returns 1 when it yields a result
    function automatic bit predict_item(input logic [SAMPLE_BITS-1:0] s,
                                        output tfd_result_t r);
        int unsigned cc;
        int unsigned ic;
        int unsigned tf;
        int unsigned cf;
        int unsigned idx;
        logic [SUM_W-1:0] tsum;
        bit made;
        cc = clamp_to(cfg_chan_count, MAX_CHANS_DEF);
        ic = clamp_to(cfg_if_count, MAX_IFS_DEF);
        tf = clamp_to(cfg_time_factor, MAX_FACTOR);
        cf = clamp_to(cfg_chan_factor, MAX_FACTOR);
        made = 1'b0;
        r = '0;
        idx = pos_if * MAX_CHANS_DEF + pos_chan;

        // first sample of a time group starts the sum afresh
        tsum = ((pos_time == 0) ? '0 : time_sums[idx]) + SUM_W'(s);
        time_sums[idx] = tsum;

        if (pos_time + 1 == tf)
        begin
            group_acc = group_acc + tsum;
            if (pos_group + 1 == cf)
            begin
                r.value        = VALUE_W'(group_acc / cf);
                r.out_channel  = OUT_CHAN_W'(pos_chan / cf);
                r.if_index     = IF_IDX_W'(pos_if);
                r.config_error = (cfg_time_factor == 0) || (cfg_time_factor > MAX_FACTOR) ||
                                 (cfg_chan_factor == 0) || (cfg_chan_factor > MAX_FACTOR) ||
                                 ((cc % cf) != 0);
                made = 1'b1;
                group_acc = '0;
                pos_group = '0;
            end
            else
                pos_group = pos_group + 1'b1;
        end

        // channel wrap drops any unfinished channel group
        pos_chan = pos_chan + 1'b1;
        if (pos_chan >= cc)
        begin
            pos_chan  = '0;
            pos_group = '0;
            group_acc = '0;
            pos_if    = pos_if + 1'b1;
            if (pos_if >= ic)
            begin
                pos_if   = '0;
                pos_time = pos_time + 1'b1;
                if (pos_time >= tf)
                    pos_time = '0;
            end
        end
        return made;
    endfunction

    // Mostly back-to-back, sometimes short gaps, rarely long ones
    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] make_sample(input int mode);
        int r;
        if (mode == 2)
            return '1;
        if (mode == 1)
        begin
            r = $urandom_range(0, 3);
            if (r == 0)
                return '0;
            if (r == 1)
                return '1;
        end
        return $urandom_range(0, (1 << SAMPLE_BITS) - 1);
    endfunction

    function automatic stim_row_t w_row(input cfg_reg_t idx, input int unsigned data);
        stim_row_t r;
        r.is_write = 1'b1;
        r.reg_idx  = idx;
        r.data     = CFG_DATA_W'(data);
        r.sample   = '0;
        r.typed    = 1'b0;
        r.want     = '0;
        return r;
    endfunction

    function automatic stim_row_t s_row(input int unsigned s);
        stim_row_t r;
        r.is_write = 1'b0;
        r.reg_idx  = REG_CHAN_COUNT;
        r.data     = '0;
        r.sample   = SAMPLE_BITS'(s);
        r.typed    = 1'b0;
        r.want     = '0;
        return r;
    endfunction

    // Row with a typed expectation: value equals the sample, channel 0, IF 0
    function automatic stim_row_t t_row(input int unsigned s, input logic err);
        stim_row_t r;
        r = s_row(s);
        r.typed = 1'b1;
        r.want.value = VALUE_W'(s);
        r.want.config_error = err;
        return r;
    endfunction

    // Offer one sample item; called and returns at a falling edge
    task automatic put_sample(input logic [SAMPLE_BITS-1:0] s, input bit typed,
                              input tfd_result_t want);
        int gap;
        tfd_result_t got;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.sample <= s;
        do
            @(posedge clk);
        while (!(in_ch.valid && in_ch.ready));
        if (predict_item(s, got) && !typed)
            pending_results.push_back(got);
        if (typed)
            pending_results.push_back(want);
        @(negedge clk);
    endtask

    // Stop offering, wait for every expected result, then let the divider drain
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(negedge clk);
        wr_en <= 1'b0;
        @(negedge clk);
        case (idx)
            REG_CHAN_COUNT:  cfg_chan_count  = data[CHAN_COUNT_W-1:0];
            REG_IF_COUNT:    cfg_if_count    = data[IF_COUNT_W-1:0];
            REG_TIME_FACTOR: cfg_time_factor = data[FACTOR_W-1:0];
            REG_CHAN_FACTOR: cfg_chan_factor = data[FACTOR_W-1:0];
        endcase
        // any write restarts the stream at a new time group
        pos_chan  = '0;
        pos_if    = '0;
        pos_group = '0;
        pos_time  = '0;
        group_acc = '0;
    endtask

    // One phase: all four registers in a randomly rotated order, then a sample stream
    task automatic run_phase(input int unsigned cc, input int unsigned ic,
                             input int unsigned tf, input int unsigned cf,
                             input int unsigned n_items, input int mode);
        int first;
        int unsigned junk;
        settle();
        first = $urandom_range(0, 3);
        for (int k = 0; k < 4; k++)
        begin
            // unused high data bits are set now and then; the block must drop them
            junk = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
            case ((first + k) % 4)
                0: write_reg(REG_CHAN_COUNT, CFG_DATA_W'(cc));
                1: write_reg(REG_IF_COUNT, CFG_DATA_W'(ic | ((junk * 511) << IF_COUNT_W)));
                2: write_reg(REG_TIME_FACTOR, CFG_DATA_W'(tf | (junk << FACTOR_W)));
                default: write_reg(REG_CHAN_FACTOR, CFG_DATA_W'(cf | (junk << FACTOR_W)));
            endcase
        end
        for (int unsigned i = 0; i < n_items; i++)
            put_sample(make_sample(mode), 1'b0, '0);
    endtask

    // Result checker: each accepted item against the oldest expectation
    always @(posedge clk)
    begin
        tfd_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result item: value %0d channel %0d if %0d",
                       out_ch.value, out_ch.out_channel, out_ch.if_index);
                err_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_ch.value !== want.value)
                begin
                    $error("value: expected %0d, got %0d", want.value, out_ch.value);
                    err_count++;
                end
                if (out_ch.out_channel !== want.out_channel)
                begin
                    $error("out_channel: expected %0d, got %0d",
                           want.out_channel, out_ch.out_channel);
                    err_count++;
                end
                if (out_ch.if_index !== want.if_index)
                begin
                    $error("if_index: expected %0d, got %0d", want.if_index, out_ch.if_index);
                    err_count++;
                end
                if (out_ch.config_error !== want.config_error)
                begin
                    $error("config_error: expected %0d, got %0d",
                           want.config_error, out_ch.config_error);
                    err_count++;
                end
            end
        end
    end

    // Result side: random ready runs and stalls, plus one long hold-off on request
    initial
    begin
        int stall;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (long_hold)
            begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                long_hold = 1'b0;
            end
            else
            begin
                stall = pick_gap();
                if (stall > 0)
                begin
                    out_ch.ready <= 1'b0;
                    repeat (stall) @(negedge clk);
                end
                out_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(negedge clk);
            end
        end
    end

    // Stimulus
    initial
    begin
        stim_row_t   rows [$];
        int unsigned sent;
        int unsigned cc;
        int unsigned ic;
        int unsigned tf;
        int unsigned cf;
        int unsigned cc_e;
        int unsigned frame;
        int unsigned n;
        int unsigned d;
        int          r;
        int          mode;

        in_ch.valid  = 1'b0;
        in_ch.sample = '0;
        wr_en        = 1'b0;
        wr_index     = '0;
        wr_data      = '0;
        rst_n        = 1'b0;
        err_count    = 0;
        steady       = 1'b0;
        long_hold    = 1'b0;
        cfg_chan_count  = 1;
        cfg_if_count    = 1;
        cfg_time_factor = 1;
        cfg_chan_factor = 1;
        pos_chan  = '0;
        pos_if    = '0;
        pos_group = '0;
        pos_time  = '0;
        group_acc = '0;

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings pass every sample straight through
        rows.push_back(t_row(0, 1'b0));
        rows.push_back(t_row(65535, 1'b0));
        rows.push_back(t_row(16'hAAAA, 1'b0));
        rows.push_back(t_row(16'h5555, 1'b0));
        // zero time factor: grouped as one, flagged
        rows.push_back(w_row(REG_TIME_FACTOR, 0));
        rows.push_back(t_row(1234, 1'b1));
        // zero channel factor: averaged as one, flagged
        rows.push_back(w_row(REG_TIME_FACTOR, 1));
        rows.push_back(w_row(REG_CHAN_FACTOR, 0));
        rows.push_back(t_row(7, 1'b1));
        // factor larger than the channel count: group never completes
        rows.push_back(w_row(REG_CHAN_FACTOR, 3));
        rows.push_back(s_row(100));
        rows.push_back(s_row(200));
        // time factor above the limit is clamped
        rows.push_back(w_row(REG_TIME_FACTOR, 511));
        rows.push_back(s_row(5));
        rows.push_back(s_row(6));
        // two IFs of four channels, pairs averaged with truncation
        rows.push_back(w_row(REG_TIME_FACTOR, 1));
        rows.push_back(w_row(REG_CHAN_COUNT, 4));
        rows.push_back(w_row(REG_IF_COUNT, 2));
        rows.push_back(w_row(REG_CHAN_FACTOR, 2));
        rows.push_back(s_row(65535));
        rows.push_back(s_row(65534));
        rows.push_back(s_row(0));
        rows.push_back(s_row(1));
        rows.push_back(s_row(65535));
        rows.push_back(s_row(65535));
        rows.push_back(s_row(0));
        rows.push_back(s_row(0));
        // zero channel and IF counts are taken as one
        rows.push_back(w_row(REG_CHAN_COUNT, 0));
        rows.push_back(w_row(REG_IF_COUNT, 0));
        rows.push_back(w_row(REG_CHAN_FACTOR, 1));
        rows.push_back(t_row(99, 1'b0));
        // IF count above the limit is clamped to four
        rows.push_back(w_row(REG_IF_COUNT, 7));
        rows.push_back(s_row(10));
        rows.push_back(s_row(20));
        rows.push_back(s_row(30));
        rows.push_back(s_row(40));
        rows.push_back(s_row(50));

        foreach (rows[i])
        begin
            if (rows[i].is_write)
            begin
                settle();
                write_reg(rows[i].reg_idx, rows[i].data);
            end
            else
                put_sample(rows[i].sample, rows[i].typed, rows[i].want);
        end

        // Full-scale time sum: 256 samples at maximum
        run_phase(1, 1, 256, 1, 512, 2);
        // Long hold-off on the result side while every item makes a result
        long_hold = 1'b1;
        steady = 1'b1;
        run_phase(2, 1, 1, 1, 80, 0);
        steady = 1'b0;
        // Channel count above the limit, widest channel groups
        run_phase(8191, 1, 1, 256, 600, 0);
        sent = 512 + 80 + 600;

        while (sent < RANDOM_ITEMS + 1192)
        begin
            r = $urandom_range(0, 29);
            if (r == 0)
                cc = ($urandom_range(0, 1) != 0) ? 4096 : $urandom_range(1, 8191);
            else if (r < 3)
                cc = 0;
            else
                cc = $urandom_range(1, 12);
            cc_e = clamp_to(cc, MAX_CHANS_DEF);
            ic = $urandom_range(0, 7);

            r = $urandom_range(0, 9);
            if (r < 7)
                tf = $urandom_range(1, 4);
            else if (r == 7)
                tf = 0;
            else if (r == 8)
                tf = MAX_FACTOR;
            else
                tf = $urandom_range(MAX_FACTOR + 1, 511);

            r = $urandom_range(0, 9);
            if (r < 6)
            begin
                // a divisor of the channel count
                do
                    d = $urandom_range(1, (cc_e < 16) ? cc_e : 16);
                while ((cc_e % d) != 0);
                cf = d;
            end
            else if (r < 8)
                cf = $urandom_range(1, 8);
            else if (r == 8)
                cf = ($urandom_range(0, 1) != 0) ? 0 : MAX_FACTOR;
            else
                cf = $urandom_range(MAX_FACTOR + 1, 511);

            // whole frames mostly, sometimes with an unfinished time group at the end
            frame = cc_e * clamp_to(ic, MAX_IFS_DEF) * clamp_to(tf, MAX_FACTOR);
            if (frame > 400)
                n = $urandom_range(300, 600);
            else
            begin
                n = frame * $urandom_range(1, 400 / frame);
                if ($urandom_range(0, 1) != 0)
                    n = n + $urandom_range(0, frame - 1);
            end

            r = $urandom_range(0, 5);
            mode = (r < 4) ? 0 : r - 3;
            steady = ($urandom_range(0, 4) == 0);
            run_phase(cc, ic, tf, cf, n, mode);
            sent = sent + n;
        end
        steady = 1'b0;

        settle();
        repeat (100) @(negedge clk);
        if (err_count == 0 && pending_results.size() == 0)
            $display("time_frequency_decimator_test: clean");
        else
            $display("time_frequency_decimator_test: errors");
        $finish;
    end

    // Watchdog
    initial
    begin
        #3000000;
        $display("time_frequency_decimator_test: errors");
        $finish;
    end

endmodule
